FILE: design/assert_macros.svh
// Assertion macros for the design files; only the datapath includes them.
// In synthesis builds the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define GHW_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define GHW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define GHW_ASSERT(lbl, clk, rst, cond)
`define GHW_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: design/ghw_pkg.sv
// ----------------------------------------------------------------------------
// ghw_pkg
// Types, constants and the arctangent table for the heading block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ghw_pkg;

  localparam int WINDOW_MAX   = 16;
  localparam int PTR_W        = $clog2(WINDOW_MAX);
  localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
  localparam int MIN_WINDOW   = 2;
  localparam int CORDIC_STEPS = 16;
  localparam int CITER_W      = $clog2(CORDIC_STEPS);
  localparam int SPEED_SCALE  = 62500;
  localparam int MSTEP_LAST   = 7;

  // register indexes
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic        RST_ENABLE    = 1'b1;
  localparam logic [4:0]  RST_WINDOW    = 5'd10;
  localparam logic [15:0] RST_THRESHOLD = 16'd256;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        fix_time;
  } fix_t;

  typedef struct packed {
    logic               yaw_valid;
    logic signed [15:0] yaw_angle;
  } head_t;

  typedef struct packed {
    logic               accept;
    logic               diff;
    logic               mul;
    logic               acc;
    logic               cmp;
    logic               cinit;
    logic               citer;
    logic               load_out;
    logic [2:0]         mstep;
    logic [CITER_W-1:0] cidx;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic can_load;
  } stat_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/gps_heading_from_window.sv
// A fix that passes the speed test goes through the difference, multiply, compare
// and CORDIC steps; one that fails it skips the CORDIC rotations, and one seen when
// disabled, short of fixes or with time not increasing skips the multiply steps too.
// The full path runs 8 multiply steps on one shared multiplier and 16 CORDIC
// rotations; a new fix is taken only once the last result is loaded, and a held result adds stalls.
// Reset: synchronous; enable 1, window 10, threshold 256, ring empty.
// ----------------------------------------------------------------------------
// gps_heading_from_window
// Course over ground from the oldest and newest fix of a window of fixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gps_heading_from_window (
  input  logic           clk,
  input  logic           rst,
  input  logic           fix_valid,
  output logic           fix_stall,
  input  ghw_pkg::fix_t  fix,
  output logic           head_valid,
  input  logic           head_stall,
  output ghw_pkg::head_t head,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import ghw_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  ghw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fix_valid (fix_valid),
    .fix_stall (fix_stall),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ghw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .fix        (fix),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .head       (head),
    .head_valid (head_valid),
    .head_stall (head_stall)
  );

endmodule

FILE: design/ghw_ctrl.sv
// ----------------------------------------------------------------------------
// ghw_ctrl
// Sequencer: fix capture, difference, multiply steps, compare, CORDIC, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ghw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           fix_valid,
  output logic           fix_stall,
  output logic           cfg_ready,
  input  ghw_pkg::stat_t stat,
  output ghw_pkg::cmd_t  cmd
);
  import ghw_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_READ  = 9'b000000010,
    S_CHK   = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_ACC   = 9'b000010000,
    S_CMP   = 9'b000100000,
    S_CINIT = 9'b001000000,
    S_CITER = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t             state, state_next;
  logic [2:0]         mstep;
  logic [CITER_W-1:0] cidx;

  // a waiting fix goes first, so a register write never meets an accept
  assign fix_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !fix_valid;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mstep    = mstep;
    cmd.cidx     = cidx;
    case (state)
      S_IDLE: begin
        if (fix_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.diff   = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = stat.ok ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = (mstep == 3'(MSTEP_LAST)) ? S_CMP : S_MUL;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_CINIT;
      end
      S_CINIT: begin
        cmd.cinit  = 1'b1;
        state_next = stat.ok ? S_CITER : S_DONE;
      end
      S_CITER: begin
        cmd.citer  = 1'b1;
        if (cidx == CITER_W'(CORDIC_STEPS - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.can_load) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mstep <= '0;
      cidx  <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) mstep <= '0;
      else if (state == S_ACC) mstep <= mstep + 3'd1;
      if (state == S_IDLE) cidx <= '0;
      else if (state == S_CITER) cidx <= cidx + CITER_W'(1);
    end
  end

endmodule

FILE: design/ghw_dp.sv
// ----------------------------------------------------------------------------
// ghw_dp
// Datapath: config registers, fix ring, multiply-accumulate, CORDIC, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ghw_dp (
  input  logic           clk,
  input  logic           rst,
  input  ghw_pkg::fix_t  fix,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  input  ghw_pkg::cmd_t  cmd,
  output ghw_pkg::stat_t stat,
  output ghw_pkg::head_t head,
  output logic           head_valid,
  input  logic           head_stall
);
  import ghw_pkg::*;

  // config
  logic        yaw_enable;
  logic [4:0]  window_length;
  logic [15:0] speed_threshold;

  // ring control
  logic [PTR_W-1:0] wp, wp_next, oldest;
  logic [CNT_W-1:0] fill, fill_new, cap, wp_inc;

  logic [95:0] ring [WINDOW_MAX];
  logic [95:0] rd;
  fix_t        nw;

  logic               ok;
  logic signed [32:0] dx, dy;
  logic [31:0]        dt;
  logic [32:0]        mx, my;

  logic [33:0]  opa, opb;
  logic [67:0]  prod;
  logic [95:0]  acc, lhs, rhs;
  logic [66:0]  lsum;
  logic [31:0]  tsq;
  logic [63:0]  dsq;

  logic signed [51:0] cx, cy, xs, ys;
  logic signed [33:0] cz, zr;
  logic               zero;
  logic signed [51:0] ix, iy;
  logic               out_full;
  head_t              out_word;

  // window capacity and pointer updates
  always_comb begin
    if (32'(window_length) > 32'(WINDOW_MAX)) cap = CNT_W'(WINDOW_MAX);
    else if (window_length < 5'(MIN_WINDOW)) cap = CNT_W'(MIN_WINDOW);
    else cap = CNT_W'(window_length);
    wp_inc   = CNT_W'(wp) + CNT_W'(1);
    wp_next  = (wp_inc == cap) ? '0 : wp_inc[PTR_W-1:0];
    fill_new = (fill < cap) ? fill + CNT_W'(1) : cap;
    oldest   = (fill_new < cap) ? '0 : wp_next;
  end

  // config registers and ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_enable      <= RST_ENABLE;
      window_length   <= RST_WINDOW;
      speed_threshold <= RST_THRESHOLD;
      wp              <= '0;
      fill            <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: begin
          yaw_enable <= cfg_data[0];
          wp <= '0;
          fill <= '0;
        end
        REG_WINDOW: begin
          window_length <= cfg_data[4:0];
          wp <= '0;
          fill <= '0;
        end
        REG_THRESHOLD: begin
          speed_threshold <= cfg_data;
          wp <= '0;
          fill <= '0;
        end
        default: ;
      endcase
    end else if (cmd.accept) begin
      wp   <= wp_next;
      fill <= fill_new;
    end
  end

  // ring memory: write newest, read oldest
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring[wp] <= {fix.pos_x, fix.pos_y, fix.fix_time};
      rd       <= ring[oldest];
      nw       <= fix;
    end
  end

  // differences and validity flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ok <= 1'b0;
    end else if (cmd.accept) begin
      ok <= yaw_enable && (fill_new >= CNT_W'(MIN_WINDOW));
    end else if (cmd.diff) begin
      ok <= ok && (nw.fix_time > rd[31:0]);
    end else if (cmd.cmp) begin
      ok <= ok && (lhs >= rhs);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx <= 33'(nw.pos_x) - 33'($signed(rd[95:64]));
      dy <= 33'(nw.pos_y) - 33'($signed(rd[63:32]));
      dt <= nw.fix_time - rd[31:0];
    end
  end

  assign mx = dx[32] ? 33'(-dx) : 33'(dx);
  assign my = dy[32] ? 33'(-dy) : 33'(dy);

  // multiplier operand select per step
  always_comb begin
    case (cmd.mstep)
      3'd0: begin opa = 34'(mx);          opb = 34'(mx); end
      3'd1: begin opa = 34'(my);          opb = 34'(my); end
      3'd2: begin opa = lsum[33:0];       opb = 34'(SPEED_SCALE); end
      3'd3: begin opa = 34'(lsum[66:34]); opb = 34'(SPEED_SCALE); end
      3'd4: begin opa = 34'(speed_threshold); opb = 34'(speed_threshold); end
      3'd5: begin opa = 34'(dt);          opb = 34'(dt); end
      3'd6: begin opa = 34'(dsq[31:0]);   opb = 34'(tsq); end
      3'd7: begin opa = 34'(dsq[63:32]);  opb = 34'(tsq); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // product register, then accumulate into the step's destination
  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= opa * opb;
    if (cmd.acc) begin
      case (cmd.mstep)
        3'd0: acc  <= 96'(prod);
        3'd1: lsum <= 67'(acc + 96'(prod));
        3'd2: acc  <= 96'(prod);
        3'd3: lhs  <= acc + (96'(prod) << 34);
        3'd4: tsq  <= prod[31:0];
        3'd5: dsq  <= prod[63:0];
        3'd6: acc  <= 96'(prod);
        3'd7: rhs  <= acc + (96'(prod) << 32);
        default: ;
      endcase
    end
  end

  // CORDIC vectoring, one rotation per cycle
  assign ix = {{3{dx[32]}}, dx, 16'd0};
  assign iy = {{3{dy[32]}}, dy, 16'd0};
  assign xs = cx >>> cmd.cidx;
  assign ys = cy >>> cmd.cidx;

  always_ff @(posedge clk) begin
    if (cmd.cinit) begin
      zero <= (dx == 33'sd0) && (dy == 33'sd0);
      if (!dx[32]) begin
        cx <= ix; cy <= iy; cz <= '0;
      end else if (!dy[32]) begin
        cx <= iy; cy <= -ix; cz <= 34'sd1073741824;
      end else begin
        cx <= -iy; cy <= ix; cz <= -34'sd1073741824;
      end
    end else if (cmd.citer) begin
      if (!cy[51]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + $signed(34'(atan_entry(5'(cmd.cidx))));
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - $signed(34'(atan_entry(5'(cmd.cidx))));
      end
    end
  end

  // round to pi/32768 and build result word
  assign zr = cz + 34'sd32768;
  always_comb begin
    out_word.yaw_valid = ok;
    out_word.yaw_angle = (ok && !zero) ? zr[31:16] : 16'sd0;
  end

  // output register
  assign stat.can_load = !out_full || !head_stall;
  assign stat.ok       = ok;
  assign head_valid    = out_full;

  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (cmd.load_out) out_full <= 1'b1;
    else if (!head_stall) out_full <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) head <= out_word;
  end

  `GHW_ASSERT(a_fill_cap, clk, rst, fill <= cap)
  `GHW_ASSERT(a_wp_cap, clk, rst, CNT_W'(wp) < cap)
  `GHW_ASSERT_IMP(a_wp_fill, clk, rst, fill < cap, CNT_W'(wp) == fill)
  `GHW_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.load_out, !(out_full && head_stall))

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives position fixes through the heading block under random valid gaps
// and result stalls. An in-bench course-over-ground predictor, covering the
// ring, the speed test and the CORDIC arctangent, checks every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import ghw_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_WAIT = 60;
  localparam int CYCLE_LIMIT = 600000;

  // Course predictor plus the queue of headings still owed by the block
  class heading_scoreboard;
    bit           enable;
    logic [4:0]   window;
    logic [15:0]  thresh;
    longint       ring_x[WINDOW_MAX];
    longint       ring_y[WINDOW_MAX];
    logic [31:0]  ring_t[WINDOW_MAX];
    int unsigned  wr_ptr;
    int unsigned  fill;
    head_t        owed[$];
    int           errors;
    longint       atan_lut[16];

    function new();
      atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331,
                   21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                   333772, 166886, 83443, 41722, 20861};
      enable = RST_ENABLE;
      window = RST_WINDOW;
      thresh = RST_THRESHOLD;
      wr_ptr = 0;
      fill = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_ENABLE: enable = data[0];
        REG_WINDOW: window = data[4:0];
        REG_THRESHOLD: thresh = data;
        default: return;
      endcase
      wr_ptr = 0;
      fill = 0;
    endfunction

    function logic [15:0] heading(longint dx, longint dy);
      longint x, y, z, t, xs, ys;
      x = dx;
      y = dy;
      z = 0;
      if (x == 0 && y == 0) return 16'd0;
      x = x * 65536;
      y = y * 65536;
      // fold the left half plane onto the right one
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 1073741824;
        end else begin
          t = x; x = -y; y = t; z = -1073741824;
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += atan_lut[i];
        end else begin
          x -= ys; y += xs; z -= atan_lut[i];
        end
      end
      z = (z + 32768) >>> 16;
      return z[15:0];
    endfunction

    function void note_fix(fix_t f);
      int unsigned cap, wp, newest, oldest;
      longint dx, dy;
      logic [127:0] ax, ay, lhs, rhs, dt;
      head_t h;
      cap = (window > WINDOW_MAX) ? WINDOW_MAX : window;
      if (cap < MIN_WINDOW) cap = MIN_WINDOW;
      wp = wr_ptr % cap;
      ring_x[wp] = longint'(f.pos_x);
      ring_y[wp] = longint'(f.pos_y);
      ring_t[wp] = f.fix_time;
      newest = wp;
      wr_ptr = (wp + 1) % cap;
      if (fill < cap) fill++;
      if (fill > cap) fill = cap;
      oldest = (fill < cap) ? 0 : wr_ptr;
      h = '0;
      if (enable && fill >= MIN_WINDOW && ring_t[newest] > ring_t[oldest]) begin
        dt = ring_t[newest] - ring_t[oldest];
        dx = ring_x[newest] - ring_x[oldest];
        dy = ring_y[newest] - ring_y[oldest];
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        // exact speed test, no division
        lhs = (ax * ax + ay * ay) * SPEED_SCALE;
        rhs = dt * dt * (128'(thresh) * 128'(thresh));
        if (lhs >= rhs) begin
          h.yaw_valid = 1'b1;
          h.yaw_angle = heading(dx, dy);
        end
      end
      owed.insert(owed.size(), h);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_word(head_t got);
      head_t exp;
      if (owed.size() == 0) begin
        report("heading word with none expected");
        return;
      end
      exp = owed[0];
      owed.delete(0);
      if (got.yaw_valid !== exp.yaw_valid)
        report($sformatf("yaw_valid got %b exp %b", got.yaw_valid, exp.yaw_valid));
      if (got.yaw_angle !== exp.yaw_angle)
        report($sformatf("yaw_angle got %0d exp %0d", got.yaw_angle, exp.yaw_angle));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        fix_valid;
  logic        fix_stall;
  fix_t        fix;
  logic        head_valid;
  logic        head_stall;
  head_t       head;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  heading_scoreboard sb;
  int          stall_left;
  bit          quiet;
  int          cycles = 0;
  logic [31:0] cur_x, cur_y, cur_t;
  int          step_scale;

  gps_heading_from_window dut (
    .clk(clk), .rst(rst),
    .fix_valid(fix_valid), .fix_stall(fix_stall), .fix(fix),
    .head_valid(head_valid), .head_stall(head_stall), .head(head),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Result side: check accepted words, then stall a random count per word
  always @(posedge clk) begin
    if (rst) begin
      head_stall <= 1'b0;
      stall_left <= 0;
    end else if (head_valid && !head_stall) begin
      sb.check_word(head);
      stall_left <= quiet ? 0 : $urandom_range(0, 12);
      head_stall <= 1'b0;
    end else if (stall_left > 0) begin
      head_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      head_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Called on a rising edge; leaves the word on the bus once accepted.
  task send_fix(logic [31:0] x, logic [31:0] y, logic [31:0] t);
    fix_t f;
    int gap;
    f.pos_x = x;
    f.pos_y = y;
    f.fix_time = t;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      fix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fix <= f;
    fix_valid <= 1'b1;
    do @(posedge clk); while (fix_stall);
    sb.note_fix(f);
  endtask

  // Drain everything owed, let the block settle, then write a register
  task write_reg(logic [1:0] idx, logic [15:0] data);
    fix_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Trajectory step, or now and then a fully random fix
  task next_fix();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      cur_t = cur_t + ((sel < 5) ? 32'd0 : $urandom_range(1, 1000));
      cur_x = cur_x + $urandom_range(0, 2 * step_scale) - step_scale;
      cur_y = cur_y + $urandom_range(0, 2 * step_scale) - step_scale;
    end else begin
      cur_x = $urandom;
      cur_y = $urandom;
      cur_t = (sel < 92) ? $urandom : cur_t - $urandom_range(0, 500);
    end
    send_fix(cur_x, cur_y, cur_t);
  endtask

  initial begin
    logic [4:0] w;
    int unsigned pick;
    sb = new();
    rst = 1'b1;
    fix_valid = 1'b0;
    fix = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    quiet = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes under the reset settings
    send_fix(32'h8000_0000, 32'h8000_0000, 32'd0);
    send_fix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
    send_fix(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_fix(32'h0, 32'h0, 32'hFFFF_FFFF);
    send_fix(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0005);
    // Two-fix window, zero threshold: standing still, heading of pi, time back
    write_reg(REG_WINDOW, 16'd2);
    write_reg(REG_THRESHOLD, 16'd0);
    send_fix(32'd5, 32'd5, 32'd100);
    send_fix(32'd5, 32'd5, 32'd200);
    send_fix(-32'sd100, 32'd5, 32'd300);
    send_fix(-32'sd100, 32'd5, 32'd300);
    send_fix(32'd0, -32'sd7, 32'd50);
    send_fix(32'd0, 32'd0, 32'd60);
    send_fix(32'd0, 32'd10, 32'd70);
    write_reg(REG_THRESHOLD, 16'hFFFF);
    send_fix(32'd0, 32'd0, 32'd0);
    send_fix(32'h7FFF_FFFF, 32'h0, 32'd1);
    send_fix(32'd0, 32'd0, 32'd100000);
    // Disabled, then an unknown register that must keep the ring
    write_reg(REG_ENABLE, 16'hFFFE);
    send_fix(32'd1, 32'd2, 32'd10);
    send_fix(32'd900, 32'd900, 32'd20);
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_THRESHOLD, 16'd0);
    send_fix(32'd1, 32'd2, 32'd10);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_fix(32'd900, -32'sd900, 32'd20);
    // Window beyond the ring size, then below the minimum
    write_reg(REG_WINDOW, 16'hFFFF);
    for (int i = 0; i < 18; i++) send_fix(i * 37, -i * 11, i * 3);
    write_reg(REG_WINDOW, 16'd1);
    send_fix(32'd3, 32'd4, 32'd5);
    send_fix(32'd30, 32'd40, 32'd50);

    // Random phases, settings redrawn between them
    cur_x = $urandom;
    cur_y = $urandom;
    cur_t = $urandom_range(0, 1000);
    for (int ph = 0; ph < 12; ph++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: w = 5'd0;
        1: w = 5'd2;
        2: w = 5'd16;
        3: w = 5'd31;
        default: w = 5'($urandom_range(1, 16));
      endcase
      write_reg(REG_WINDOW, {11'($urandom_range(0, 2047)), w});
      pick = $urandom_range(0, 5);
      case (pick)
        0: write_reg(REG_THRESHOLD, 16'd0);
        1: write_reg(REG_THRESHOLD, 16'hFFFF);
        2: write_reg(REG_THRESHOLD, 16'($urandom));
        default: write_reg(REG_THRESHOLD, 16'($urandom_range(0, 8000)));
      endcase
      write_reg(REG_ENABLE, ($urandom_range(0, 7) == 0) ? 16'd0 : 16'd1);
      pick = $urandom_range(0, 2);
      step_scale = (pick == 0) ? 100 : (pick == 1) ? 5000 : 200000;
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 45; i++) next_fix();
      quiet = 1'b0;
    end

    fix_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
